FILE: hdl/tbss_pkg.sv
// Shared types and constants for the TDMA beacon slot scheduler.
// No dependencies; imported by the front, queue, back and top modules.
`default_nettype none

package tbss_pkg;

    // Input kind carried in tuser
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_BYTE = 1'b1;

    // Anchor state codes
    localparam logic [1:0] ANCHOR_SILENT    = 2'd0;
    localparam logic [1:0] ANCHOR_TRACKING  = 2'd1;
    localparam logic [1:0] ANCHOR_DISCOVERY = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SLOT_NUMBER = 2'd0;
    localparam logic [1:0] CFG_BEACON_TYPE = 2'd1;
    localparam logic [1:0] CFG_LOSS_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_DISC_PERIOD = 2'd3;

    // Beacon layout
    localparam int BEACON_LENGTH = 12;
    localparam logic [3:0] POS_CHECKSUM = 4'd11;
    localparam logic [3:0] POS_SAT = 4'd15;
    localparam logic [3:0] POS_UNTIL_0 = 4'd1;
    localparam logic [3:0] POS_UNTIL_1 = 4'd2;
    localparam logic [3:0] POS_UNTIL_2 = 4'd3;
    localparam logic [3:0] POS_CYCLE_0 = 4'd4;
    localparam logic [3:0] POS_CYCLE_1 = 4'd5;
    localparam logic [3:0] POS_STRIDE_0 = 4'd6;
    localparam logic [3:0] POS_STRIDE_1 = 4'd7;
    localparam logic [3:0] POS_HEAD = 4'd8;

    localparam logic [19:0] MAX_WAIT = 20'd1000000;
    localparam logic [23:0] SINCE_SAT = 24'hFFFFFF;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_SLOT_NUMBER = 8'd255;
    localparam logic [7:0]  RST_BEACON_TYPE = 8'd0;
    localparam logic [23:0] RST_LOSS_TIMEOUT = 24'd200000;
    localparam logic [23:0] RST_DISC_PERIOD = 24'd1000000;

    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 48;

    // One classified item between front and back
    typedef struct packed {
        logic        tick;      // time tick, otherwise a packet byte
        logic        taken;     // last byte of a timing beacon
        logic        bad;       // beacon XOR check failed
        logic [31:0] tx_time;   // computed transmit time
        logic [15:0] cycle;     // beacon cycle counter
    } tbss_entry_t;

endpackage

`default_nettype wire

FILE: hdl/tbss_front.sv
// Front part: assembles packet bytes, checks beacons, forms transmit time.
// Depends on tbss_pkg.
`default_nettype none

module tbss_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 take,
    input  wire logic                 cmd,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 last_byte,
    input  wire logic [31:0]          rx_time_us,
    input  wire logic [7:0]           beacon_type,
    input  wire logic [7:0]           slot_number,
    output tbss_pkg::tbss_entry_t     entry
);
    import tbss_pkg::*;

    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic        match_reg, match_next;
    logic [23:0] until_reg, until_next;
    logic [15:0] cycle_reg, cycle_next;
    logic [15:0] stride_reg, stride_next;
    logic [7:0]  head_reg, head_next;
    logic [23:0] prod_reg;
    logic [24:0] base_reg;
    logic        is_byte;
    logic        taken;

    assign is_byte = take && (cmd == CMD_BYTE);

    // Update the byte assembly for one packet byte
    always_comb
    begin
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        match_next  = match_reg;
        until_next  = until_reg;
        cycle_next  = cycle_reg;
        stride_next = stride_reg;
        head_next   = head_reg;
        if (pos_reg == 4'd0)
        begin
            match_next = (data_byte == beacon_type);
        end
        if (pos_reg <= POS_CHECKSUM)
        begin
            xor_next = xor_reg ^ data_byte;
        end
        case (pos_reg)
            POS_UNTIL_0:  until_next[7:0]   = data_byte;
            POS_UNTIL_1:  until_next[15:8]  = data_byte;
            POS_UNTIL_2:  until_next[23:16] = data_byte;
            POS_CYCLE_0:  cycle_next[7:0]   = data_byte;
            POS_CYCLE_1:  cycle_next[15:8]  = data_byte;
            POS_STRIDE_0: stride_next[7:0]  = data_byte;
            POS_STRIDE_1: stride_next[15:8] = data_byte;
            POS_HEAD:     head_next         = data_byte;
            default:      ;
        endcase
        if (pos_reg != POS_SAT)
        begin
            pos_next = pos_reg + 4'd1;
        end
    end

    // Classify the last byte of a packet
    assign taken = last_byte && match_next && (pos_next >= 4'(BEACON_LENGTH));

    always_comb
    begin
        entry.tick    = (cmd == CMD_TICK);
        entry.taken   = is_byte && taken;
        entry.bad     = is_byte && taken && (xor_next != 8'd0);
        entry.tx_time = rx_time_us + {7'd0, base_reg};
        entry.cycle   = cycle_reg;
    end

    // Hold the assembly; clear it after every last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            xor_reg    <= '0;
            match_reg  <= 1'b0;
            until_reg  <= '0;
            cycle_reg  <= '0;
            stride_reg <= '0;
            head_reg   <= '0;
        end
        else if (is_byte)
        begin
            if (last_byte)
            begin
                pos_reg    <= '0;
                xor_reg    <= '0;
                match_reg  <= 1'b0;
                until_reg  <= '0;
                cycle_reg  <= '0;
                stride_reg <= '0;
                head_reg   <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                xor_reg    <= xor_next;
                match_reg  <= match_next;
                until_reg  <= until_next;
                cycle_reg  <= cycle_next;
                stride_reg <= stride_next;
                head_reg   <= head_next;
            end
        end
    end

    // Precompute the slot offset; fields settle well before the last byte
    always_ff @(posedge clk)
    begin
        prod_reg <= stride_reg * slot_number;
        base_reg <= {1'b0, until_reg} + {14'd0, head_reg, 3'd0} + {1'b0, prod_reg};
    end

endmodule

`default_nettype wire

FILE: hdl/tbss_queue.sv
// Two-entry queue between the front and the back parts.
// Depends on tbss_pkg.
`default_nettype none

module tbss_queue
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire tbss_pkg::tbss_entry_t push_entry,
    output logic                      full,
    input  wire logic                 pop,
    output tbss_pkg::tbss_entry_t     pop_entry,
    output logic                      not_empty
);
    import tbss_pkg::*;

    tbss_entry_t slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tbss_back.sv
// Back part: time base, slot countdown, discovery and the output register.
// Depends on tbss_pkg.
`default_nettype none

module tbss_back
#(
    parameter int SLOT_COUNT = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire tbss_pkg::tbss_entry_t q_entry,
    output logic                      q_pop,
    input  wire logic [7:0]           slot_number,
    input  wire logic [23:0]          loss_timeout_us,
    input  wire logic [23:0]          discovery_period_us,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [tbss_pkg::OUT_DATA_W-1:0] out_data
);
    import tbss_pkg::*;

    logic [31:0] now_reg, now_next;
    logic [19:0] countdown_reg, countdown_next;
    logic        armed_reg, armed_next;
    logic [23:0] since_reg, since_next;
    logic        disc_on_reg, disc_on_next;
    logic [23:0] disc_count_reg, disc_count_next;
    logic [15:0] held_cycle_reg, held_cycle_next;
    logic [19:0] held_wait_reg, held_wait_next;
    logic        out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic        slot_ok;
    logic        fire;
    logic [1:0]  anchor;
    logic [31:0] diff;
    logic [19:0] wait_clamped;
    logic [23:0] period;
    logic [24:0] disc_inc;

    assign slot_ok   = slot_number < 8'(SLOT_COUNT);
    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign period    = (discovery_period_us == 24'd0) ? 24'd1 : discovery_period_us;
    assign disc_inc  = {1'b0, disc_count_reg} + 25'd1;

    // Clamp the wait until the transmit time
    always_comb
    begin
        diff = q_entry.tx_time - now_reg;
        if (diff[31])
        begin
            wait_clamped = 20'd0;
        end
        else if (diff > {12'd0, MAX_WAIT})
        begin
            wait_clamped = MAX_WAIT;
        end
        else
        begin
            wait_clamped = diff[19:0];
        end
    end

    // Next state for one item
    always_comb
    begin
        now_next        = now_reg;
        countdown_next  = countdown_reg;
        armed_next      = armed_reg;
        since_next      = since_reg;
        disc_on_next    = disc_on_reg;
        disc_count_next = disc_count_reg;
        held_cycle_next = held_cycle_reg;
        held_wait_next  = held_wait_reg;
        fire            = 1'b0;
        if (q_entry.tick)
        begin
            now_next = now_reg + 32'd1;
            if (since_reg != SINCE_SAT)
            begin
                since_next = since_reg + 24'd1;
            end
            if (armed_reg)
            begin
                if (countdown_reg <= 20'd1)
                begin
                    fire           = 1'b1;
                    armed_next     = 1'b0;
                    countdown_next = 20'd0;
                end
                else
                begin
                    countdown_next = countdown_reg - 20'd1;
                end
            end
            if (!slot_ok)
            begin
                disc_on_next    = 1'b0;
                disc_count_next = 24'd0;
            end
            else if (disc_on_reg)
            begin
                if (disc_inc >= {1'b0, period})
                begin
                    fire            = 1'b1;
                    disc_count_next = 24'd0;
                end
                else
                begin
                    disc_count_next = disc_inc[23:0];
                end
            end
            else if (since_next >= loss_timeout_us)
            begin
                disc_on_next    = 1'b1;
                disc_count_next = 24'd0;
            end
        end
        else if (q_entry.taken && !q_entry.bad && slot_ok)
        begin
            countdown_next  = wait_clamped;
            armed_next      = 1'b1;
            held_wait_next  = wait_clamped;
            held_cycle_next = q_entry.cycle;
            since_next      = 24'd0;
            disc_on_next    = 1'b0;
            disc_count_next = 24'd0;
        end
    end

    // Anchor state after the update
    always_comb
    begin
        if (!slot_ok)
        begin
            anchor = ANCHOR_SILENT;
        end
        else if (since_next < loss_timeout_us)
        begin
            anchor = ANCHOR_TRACKING;
        end
        else
        begin
            anchor = ANCHOR_DISCOVERY;
        end
    end

    // Commit state on each popped item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            countdown_reg  <= '0;
            armed_reg      <= 1'b0;
            since_reg      <= '0;
            disc_on_reg    <= 1'b0;
            disc_count_reg <= '0;
            held_cycle_reg <= '0;
            held_wait_reg  <= '0;
        end
        else if (q_pop)
        begin
            now_reg        <= now_next;
            countdown_reg  <= countdown_next;
            armed_reg      <= armed_next;
            since_reg      <= since_next;
            disc_on_reg    <= disc_on_next;
            disc_count_reg <= disc_count_next;
            held_cycle_reg <= held_cycle_next;
            held_wait_reg  <= held_wait_next;
        end
    end

    // Output register: load on pop, drop valid once the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= {7'd0, held_wait_next, held_cycle_next, anchor,
                             q_entry.bad, q_entry.taken, fire};
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tdma_beacon_slot_scheduler.sv
// Top level of the TDMA beacon slot scheduler: config registers, front, queue, back.
// Depends on tbss_pkg, tbss_front, tbss_queue and tbss_back.
//
//   Channel   Direction  Handshake          Payload
//   s_*       in         s_tvalid/s_tready  tdata: data_byte, rx_time_us; tlast; tuser: cmd
//   m_*       out        m_tvalid/m_tready  tdata: slot_fire .. wait_loaded
//   cfg_*     in         cfg_we             cfg_index, cfg_data
//
// One item per clock sustained while m_tready is high and no configuration write holds
// s_tready low; each item's result reaches m_tdata through the queue and the output
// register (the front writes the queue at the transfer; the back pops the item and loads
// the output register). The back part's state update is the loop that sets the rate.
// Reset clears all control state; config registers take their reset values.
// A configuration write holds s_tready low while cfg_hold_reg counts down and the slot offset
// pipeline settles. A stalled m side fills the two-entry queue, then s_tready drops.
`default_nettype none

module tdma_beacon_slot_scheduler
#(
    parameter int SLOT_COUNT = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [tbss_pkg::IN_DATA_W-1:0] s_tdata,   // [7:0] data_byte, [39:8] rx_time_us
    input  wire logic        s_tlast,
    input  wire logic        s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] slot_fire, [1] beacon_taken, [2] checksum_bad, [4:3] anchor_state,
    // [20:5] cycle_count_low, [40:21] wait_loaded, [47:41] zero
    output logic [47:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    import tbss_pkg::*;

    logic [7:0]  slot_number_reg;
    logic [7:0]  beacon_type_reg;
    logic [23:0] loss_timeout_reg;
    logic [23:0] disc_period_reg;
    logic [1:0]  cfg_hold_reg;

    tbss_entry_t front_entry;
    tbss_entry_t q_entry;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    logic        take;

    assign s_tready = !q_full && (cfg_hold_reg == 2'd0);
    assign take     = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_number_reg  <= RST_SLOT_NUMBER;
            beacon_type_reg  <= RST_BEACON_TYPE;
            loss_timeout_reg <= RST_LOSS_TIMEOUT;
            disc_period_reg  <= RST_DISC_PERIOD;
            cfg_hold_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_hold_reg <= 2'd2;
                unique case (cfg_index)
                    CFG_SLOT_NUMBER:  slot_number_reg  <= cfg_data[7:0];
                    CFG_BEACON_TYPE:  beacon_type_reg  <= cfg_data[7:0];
                    CFG_LOSS_TIMEOUT: loss_timeout_reg <= cfg_data;
                    CFG_DISC_PERIOD:  disc_period_reg  <= cfg_data;
                    default:          ;
                endcase
            end
            else if (cfg_hold_reg != 2'd0)
            begin
                cfg_hold_reg <= cfg_hold_reg - 2'd1;
            end
        end
    end

    tbss_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .cmd         (s_tuser),
        .data_byte   (s_tdata[7:0]),
        .last_byte   (s_tlast),
        .rx_time_us  (s_tdata[39:8]),
        .beacon_type (beacon_type_reg),
        .slot_number (slot_number_reg),
        .entry       (front_entry)
    );

    tbss_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (take),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_entry),
        .not_empty  (q_valid)
    );

    tbss_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .q_valid             (q_valid),
        .q_entry             (q_entry),
        .q_pop               (q_pop),
        .slot_number         (slot_number_reg),
        .loss_timeout_us     (loss_timeout_reg),
        .discovery_period_us (disc_period_reg),
        .out_valid           (m_tvalid),
        .out_ready           (m_tready),
        .out_data            (m_tdata)
    );

endmodule

`default_nettype wire

FILE: sim/tdma_beacon_slot_scheduler_tb.sv
// Self-checking testbench for the TDMA beacon slot scheduler: bytes and ticks in.
// Depends on tbss_pkg and tdma_beacon_slot_scheduler; keeps its own model of the block.
`default_nettype none

module tdma_beacon_slot_scheduler_tb;

    import tbss_pkg::*;

    localparam int SLOT_COUNT  = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int REPORT_CAP  = 100;

    typedef enum int {PKT_GOOD, PKT_BAD_SUM, PKT_FOREIGN, PKT_SHORT, PKT_LONG} pkt_kind_t;

    typedef struct packed {
        logic        fire;
        logic        taken;
        logic        bad;
        logic [1:0]  anchor;
        logic [15:0] cycle_low;
        logic [19:0] wait_us;
    } sched_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // [7:0] data_byte, [39:8] rx_time_us
    logic        s_tlast = 1'b0;
    logic        s_tuser = 1'b0;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [0] slot_fire, [1] beacon_taken, [2] checksum_bad, [4:3] anchor_state,
    // [20:5] cycle_count_low, [40:21] wait_loaded, [47:41] zero
    logic [47:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    // Model copy of the configuration
    logic [7:0]  cfg_slot;
    logic [7:0]  cfg_type;
    logic [23:0] cfg_loss;
    logic [23:0] cfg_period;

    // Model copy of the block state
    logic [31:0] m_now;
    logic [3:0]  m_pos;
    logic [7:0]  m_xor;
    logic        m_tmatch;
    logic [23:0] m_until;
    logic [15:0] m_cycle;
    logic [15:0] m_stride;
    logic [7:0]  m_head;
    logic [19:0] m_countdown;
    logic        m_armed;
    logic [23:0] m_since;
    logic        m_disc_on;
    logic [23:0] m_disc_cnt;
    logic [15:0] m_held_cycle;
    logic [19:0] m_held_wait;

    sched_result_t pending_results[$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_left = 0;
    int items_sent = 0;
    int results_seen = 0;
    int fires_seen = 0;
    int taken_seen = 0;
    int bad_seen = 0;
    int mismatches = 0;
    int cycles_run = 0;

    tdma_beacon_slot_scheduler #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles_run,
                     pending_results.size());
            $display("tdma_beacon_slot_scheduler_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Scheduler model
    // ------------------------------------------------------------------

    function automatic logic slot_ok();
        return cfg_slot < SLOT_COUNT;
    endfunction

    task automatic clear_assembly();
        m_pos    = '0;
        m_xor    = '0;
        m_tmatch = 1'b0;
        m_until  = '0;
        m_cycle  = '0;
        m_stride = '0;
        m_head   = '0;
    endtask

    task automatic reset_model();
        cfg_slot     = RST_SLOT_NUMBER;
        cfg_type     = RST_BEACON_TYPE;
        cfg_loss     = RST_LOSS_TIMEOUT;
        cfg_period   = RST_DISC_PERIOD;
        m_now        = '0;
        clear_assembly();
        m_countdown  = '0;
        m_armed      = 1'b0;
        m_since      = '0;
        m_disc_on    = 1'b0;
        m_disc_cnt   = '0;
        m_held_cycle = '0;
        m_held_wait  = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        if (m_pos == 4'd0)
            m_tmatch = (b == cfg_type);
        if (m_pos <= POS_CHECKSUM)
            m_xor = m_xor ^ b;
        case (m_pos)
            POS_UNTIL_0:  m_until[7:0]   = b;
            POS_UNTIL_1:  m_until[15:8]  = b;
            POS_UNTIL_2:  m_until[23:16] = b;
            POS_CYCLE_0:  m_cycle[7:0]   = b;
            POS_CYCLE_1:  m_cycle[15:8]  = b;
            POS_STRIDE_0: m_stride[7:0]  = b;
            POS_STRIDE_1: m_stride[15:8] = b;
            POS_HEAD:     m_head         = b;
            default: ;
        endcase
        if (m_pos != POS_SAT)
            m_pos = m_pos + 4'd1;
    endtask

    // Offset of our slot from the receive time
    function automatic logic [31:0] slot_offset(input logic [23:0] gap, input logic [7:0] head,
                                                input logic [15:0] stride);
        return {8'd0, gap} + ({24'd0, head} << 3) + {16'd0, stride} * {24'd0, cfg_slot};
    endfunction

    // Signed distance from now to the transmit time, clamped
    function automatic logic [19:0] slot_wait(input logic [31:0] rx);
        logic [31:0] diff;
        diff = rx + slot_offset(m_until, m_head, m_stride) - m_now;
        if (diff[31])
            return '0;
        if (diff > {12'd0, MAX_WAIT})
            return MAX_WAIT;
        return diff[19:0];
    endfunction

    // Advance the model by one accepted item and queue its result
    task automatic schedule_step(input logic cmd, input logic [7:0] b, input logic last,
                                 input logic [31:0] rx);
        sched_result_t r;
        logic [23:0] period;
        r = '0;
        if (cmd == CMD_TICK)
        begin
            m_now = m_now + 32'd1;
            if (m_since != SINCE_SAT)
                m_since = m_since + 24'd1;
            if (m_armed)
            begin
                if (m_countdown <= 20'd1)
                begin
                    r.fire = 1'b1;
                    m_armed = 1'b0;
                    m_countdown = '0;
                end
                else
                    m_countdown = m_countdown - 20'd1;
            end
            if (!slot_ok())
            begin
                m_disc_on = 1'b0;
                m_disc_cnt = '0;
            end
            else if (m_disc_on)
            begin
                period = (cfg_period == '0) ? 24'd1 : cfg_period;
                m_disc_cnt = m_disc_cnt + 24'd1;
                if (m_disc_cnt >= period)
                begin
                    r.fire = 1'b1;
                    m_disc_cnt = '0;
                end
            end
            else if (m_since >= cfg_loss)
            begin
                m_disc_on = 1'b1;
                m_disc_cnt = '0;
            end
        end
        else
        begin
            absorb_byte(b);
            if (last)
            begin
                if (m_pos >= BEACON_LENGTH && m_tmatch)
                begin
                    r.taken = 1'b1;
                    if (m_xor != '0)
                        r.bad = 1'b1;
                    else if (slot_ok())
                    begin
                        m_countdown  = slot_wait(rx);
                        m_armed      = 1'b1;
                        m_held_wait  = m_countdown;
                        m_held_cycle = m_cycle;
                        m_since      = '0;
                        m_disc_on    = 1'b0;
                        m_disc_cnt   = '0;
                    end
                end
                clear_assembly();
            end
        end
        if (!slot_ok())
            r.anchor = ANCHOR_SILENT;
        else if (m_since < cfg_loss)
            r.anchor = ANCHOR_TRACKING;
        else
            r.anchor = ANCHOR_DISCOVERY;
        r.cycle_low = m_held_cycle;
        r.wait_us = m_held_wait;
        pending_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Output side: ready pattern and result check
    // ------------------------------------------------------------------

    // Drive ready: a requested hold wins over the random stall pattern
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    // Compare each output transfer with the oldest predicted result
    always @(posedge clk)
    begin : result_check
        sched_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            fires_seen += m_tdata[0];
            taken_seen += m_tdata[1];
            bad_seen += m_tdata[2];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("slot_fire", want.fire, m_tdata[0]);
                check_field("beacon_taken", want.taken, m_tdata[1]);
                check_field("checksum_bad", want.bad, m_tdata[2]);
                check_field("anchor_state", want.anchor, m_tdata[4:3]);
                check_field("cycle_count_low", want.cycle_low, m_tdata[20:5]);
                check_field("wait_loaded", want.wait_us, m_tdata[40:21]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one item, hold it until the transfer, then update the model
    task automatic send_item(input logic cmd, input logic [7:0] b, input logic last,
                             input logic [31:0] rx);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rx, b};
        s_tlast  <= last;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        schedule_step(cmd, b, last, rx);
        items_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_item(CMD_TICK, 8'($urandom), 1'($urandom), $urandom);
    endtask

    // Send one packet; lead is the wanted distance from now to the slot time
    task automatic send_packet(input pkt_kind_t kind, input logic [31:0] lead);
        logic [7:0]  pkt [16];
        logic [7:0]  sum;
        logic [23:0] gap;
        logic [15:0] stride;
        logic [31:0] rx;
        int          len;
        gap    = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(300));
        stride = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20));
        for (int i = 0; i < 16; i++)
            pkt[i] = 8'($urandom);
        pkt[0] = (kind == PKT_FOREIGN) ? cfg_type ^ 8'($urandom_range(1, 255)) : cfg_type;
        {pkt[3], pkt[2], pkt[1]} = gap;
        {pkt[7], pkt[6]} = stride;
        sum = '0;
        for (int i = 0; i < 11; i++)
            sum = sum ^ pkt[i];
        pkt[11] = (kind == PKT_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
        case (kind)
            PKT_SHORT: len = $urandom_range(1, 11);
            PKT_LONG:  len = $urandom_range(13, 16);
            default:   len = BEACON_LENGTH;
        endcase
        for (int i = 0; i < len; i++)
        begin
            // Ticks may fall between bytes of a packet
            if ($urandom_range(19) == 0)
                send_ticks($urandom_range(1, 3));
            if (i == len - 1)
            begin
                rx = m_now + lead - slot_offset(gap, pkt[8], stride);
                send_item(CMD_BYTE, pkt[i], 1'b1, rx);
            end
            else
                send_item(CMD_BYTE, pkt[i], 1'b0, $urandom);
        end
    endtask

    // Mostly well-formed beacons landing close to now, plus noise
    task automatic run_traffic(input int count);
        int target;
        int pick;
        logic [31:0] lead;
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            lead = ($urandom_range(4) != 0) ? 32'($urandom_range(70)) - 32'd10 : $urandom;
            if (pick < 40)
                send_packet(PKT_GOOD, lead);
            else if (pick < 50)
                send_packet(PKT_BAD_SUM, lead);
            else if (pick < 57)
                send_packet(PKT_FOREIGN, lead);
            else if (pick < 64)
                send_packet(PKT_SHORT, lead);
            else if (pick < 70)
                send_packet(PKT_LONG, lead);
            else
                send_ticks($urandom_range(1, 40));
        end
    endtask

    // Drop valid and wait until every result is back and the block is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SLOT_NUMBER:  cfg_slot = val[7:0];
            CFG_BEACON_TYPE:  cfg_type = val[7:0];
            CFG_LOSS_TIMEOUT: cfg_loss = val;
            CFG_DISC_PERIOD:  cfg_period = val;
            default: ;
        endcase
    endtask

    // Upper bits of the 8-bit registers carry junk that must be ignored
    task automatic set_config(input logic [7:0] slot, input logic [7:0] btype,
                              input logic [23:0] loss, input logic [23:0] period);
        write_reg(CFG_SLOT_NUMBER, {16'($urandom), slot});
        write_reg(CFG_BEACON_TYPE, {16'($urandom), btype});
        write_reg(CFG_LOSS_TIMEOUT, loss);
        write_reg(CFG_DISC_PERIOD, period);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: unset slot stays silent and drops a good beacon
    task automatic test_reset_defaults();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        send_item(CMD_TICK, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        send_item(CMD_TICK, 8'h00, 1'b0, 32'h0000_0000);
        send_packet(PKT_GOOD, 32'd5);
    endtask

    // Short packet, good beacon, countdown fire, then loss into discovery
    task automatic test_beacon_cases();
        set_config(8'd2, 8'hA5, 24'd6, 24'd3);
        send_item(CMD_BYTE, 8'hA5, 1'b1, 32'h0000_0000);
        send_packet(PKT_GOOD, 32'd2);
        send_ticks(10);
    endtask

    task automatic test_steady_stream();
        set_config(8'd5, 8'h7E, 24'd40, 24'd7);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        run_traffic(350);
    endtask

    // Last valid slot, timeout and period of one
    task automatic test_sparse_sender();
        set_config(8'd15, 8'hFF, 24'd1, 24'd1);
        src_idle_pct = 84;
        sink_stall_pct = 0;
        run_traffic(300);
    endtask

    // Slot zero, zero timeout and zero period
    task automatic test_stalled_receiver();
        set_config(8'd0, 8'h00, 24'd0, 24'd0);
        src_idle_pct = 0;
        sink_stall_pct = 84;
        run_traffic(300);
    endtask

    task automatic test_mixed_idle();
        set_config(8'd9, 8'($urandom), 24'd25, 24'd5);
        src_idle_pct = 13;
        sink_stall_pct = 13;
        run_traffic(250);
    endtask

    // First slot number past the table, then the unset marker with maximal timing
    task automatic test_unset_slot();
        set_config(8'd16, 8'h3C, 24'd10000000, 24'd10000000);
        run_traffic(60);
        set_config(8'd255, 8'hC3, 24'hFFFFFF, 24'hFFFFFF);
        run_traffic(60);
    endtask

    // Long receiver hold while the sender keeps offering items
    task automatic test_backpressure();
        set_config(8'd7, 8'h5A, 24'd20, 24'd4);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = 400;
        run_traffic(100);
    endtask

    initial
    begin
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_beacon_cases();
        test_steady_stream();
        test_sparse_sender();
        test_stalled_receiver();
        test_mixed_idle();
        test_unset_slot();
        test_backpressure();
        drain();
        repeat (10) @(posedge clk);
        $display("Sent %0d items over eight phases, checked %0d results with %0d mismatches.",
                 items_sent, results_seen, mismatches);
        $display("Observed %0d slot pulses, %0d beacons taken, %0d checksum failures.",
                 fires_seen, taken_seen, bad_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tdma_beacon_slot_scheduler_tb OK");
        else
            $display("tdma_beacon_slot_scheduler_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
